### rtl/ibl_pkg.sv
`default_nettype none

package ibl_pkg;

  // Width of the incoming integer and how it is walked through the divider.
  localparam int WORD_W    = 32;
  localparam int STEP_BITS = 8;
  localparam int DIV_STEPS = WORD_W / STEP_BITS;
  localparam int STEP_CW   = $clog2(DIV_STEPS);

  // Defaults for the top-level parameters.
  localparam int DEF_RADIX      = 5;
  localparam int DEF_MAX_DIGITS = 14;

  // ASCII codes of the emitted characters.
  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CODE_A     = 7'd65;
  localparam logic [CHAR_W-1:0] CODE_MINUS = 7'd45;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NEXT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
    logic put_sign;
    logic put_char;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;
    logic is_neg;
    logic rp_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/ibl_ctrl.sv
`default_nettype none

module ibl_ctrl import ibl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t              state;
  state_t              state_next;
  logic [STEP_CW-1:0]  step;
  logic [STEP_CW-1:0]  step_next;
  logic                step_last;

  assign step_last = (step == STEP_CW'(DIV_STEPS - 1));

  // State and divide-step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        step_next = step + STEP_CW'(1);
        if (step_last) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        step_next = '0;
        if (!sts.quot_zero) begin
          state_next = ST_DIV;
        end else if (sts.is_neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.rp_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_NEXT: begin
        cmd.commit = 1'b1;
      end
      ST_SIGN: begin
        cmd.put_sign = sts.out_free;
      end
      ST_EMIT: begin
        cmd.put_char = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ibl_dp.sv
`default_nettype none

module ibl_dp import ibl_pkg::*; #(
  parameter int RADIX      = DEF_RADIX,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CHAR_W-1:0]             char_code,
  output logic                          last_char
);

  localparam int RW = (RADIX > 2) ? $clog2(RADIX) : 1;
  localparam int PW = RW + 1;
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam logic [PW-1:0] RADIX_P = PW'(RADIX);
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_DIGITS);

  logic [WORD_W-1:0] work;
  logic [RW-1:0]     rem;
  logic              neg;
  logic [NW-1:0]     nd;
  logic [IW-1:0]     rp;
  logic [RW-1:0]     digit_mem [MAX_DIGITS];

  logic [WORD_W-1:0] raw;
  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] work_div;
  logic [RW-1:0]     rem_div;
  logic [PW-1:0]     part;
  logic              room;

  // Magnitude of the incoming word; the most negative value maps onto 2^31.
  assign raw = value;
  assign mag = raw[WORD_W-1] ? (~raw + WORD_W'(1)) : raw;

  // One chunk of restoring division by the radix: the dividend shifts out at
  // the top while quotient bits shift in at the bottom.
  always_comb begin
    work_div = work;
    rem_div  = rem;
    part     = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      part     = {rem_div, work_div[WORD_W-1]};
      work_div = {work_div[WORD_W-2:0], 1'b0};
      if (part >= RADIX_P) begin
        rem_div     = RW'(part - RADIX_P);
        work_div[0] = 1'b1;
      end else begin
        rem_div = RW'(part);
      end
    end
  end

  assign room = (nd < MAX_N);

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= mag;
      rem  <= '0;
      neg  <= raw[WORD_W-1];
      nd   <= '0;
    end else if (cmd.div_step) begin
      work <= work_div;
      rem  <= rem_div;
    end else if (cmd.commit) begin
      rem <= '0;
      if (work != '0) begin
        work <= work - WORD_W'(1);
      end
      if (room) begin
        nd <= nd + NW'(1);
        rp <= IW'(nd);
      end else begin
        rp <= IW'(MAX_DIGITS - 1);
      end
    end else if (cmd.put_char) begin
      rp <= rp - IW'(1);
    end
  end

  // Digit store; digits beyond the capacity are the high ones and are dropped.
  always_ff @(posedge clk) begin
    if (cmd.commit && room) begin
      digit_mem[IW'(nd)] <= rem;
    end
  end

  // Output register: takes a new word whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_sign || cmd.put_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_sign) begin
      char_code <= CODE_MINUS;
      last_char <= 1'b0;
    end else if (cmd.put_char) begin
      char_code <= CODE_A + CHAR_W'(digit_mem[rp]);
      last_char <= (rp == '0);
    end
  end

  // Status towards the controller.
  assign sts.quot_zero = (work == '0);
  assign sts.is_neg    = neg;
  assign sts.rp_zero   = (rp == '0);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

### rtl/int_to_bijective_letters_top.sv
// Each digit passes through the 8-bit-per-cycle divide-by-radix stage (ST_DIV), then
// through a store step (ST_NEXT) that writes the digit into the digit store.
// After that, one character per cycle is loaded into the output register (sign first)
// whenever the output register is free; a stalled output holds the flow.
// The divider is shared by all digits, so one value is converted at a time.
// rst is synchronous: it clears the controller and the output valid flag.
`default_nettype none

module int_to_bijective_letters_top import ibl_pkg::*; #(
  parameter int RADIX      = DEF_RADIX,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CHAR_W-1:0]             char_code,
  output logic                          last_char
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ibl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Divider, digit store and output register.
  ibl_dp #(
    .RADIX      (RADIX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
  );

  // A shown word is either the minus sign or a letter within the radix.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CODE_MINUS ||
                   (char_code >= CODE_A && char_code < CODE_A + CHAR_W'(RADIX))))
    else $error("character code out of range");

  // The minus sign is never the final character of a spelling.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == CODE_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  // An accepted value starts a conversion, so the input closes straight away.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accepting a value");

  // The controller never loads a word into a full, stalled output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_sign || cmd.put_char) |-> sts.out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

### bench/int_to_bijective_letters_top_test.sv
`timescale 1ns / 1ps

module int_to_bijective_letters_top_test import ibl_pkg::*;;

  localparam int RADIX      = DEF_RADIX;
  localparam int MAX_DIGITS = DEF_MAX_DIGITS;
  // Words left in the queue when the random idling stops.
  localparam int CALM_TAIL  = 40;
  // Output hold-off that backs the block up into its input.
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AT    = 40;
  localparam int DRAIN_WAIT = 120;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } letter_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic signed [WORD_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CHAR_W-1:0]        char_code;
  logic                     last_char;

  logic signed [WORD_W-1:0] pending_values[$];
  letter_t                  expected_letters[$];
  int                       error_count     = 0;
  int                       accepted_values = 0;
  logic                     word_taken      = 1'b0;
  int                       in_gap          = 0;
  int                       out_gap         = 0;
  int                       long_hold       = 0;
  logic                     long_hold_done  = 1'b0;

  int_to_bijective_letters_top #(
    .RADIX     (RADIX),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .last_char(last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Spell one integer in bijective letters and queue the characters it should produce.
  function automatic void spell_value(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] quot;
    logic [CHAR_W-1:0] digit_codes[$];
    letter_t           letter;
    mag = v;
    if (v[WORD_W-1]) mag = ~mag + 1'b1;
    // Digits are found least significant first, so each goes to the front.
    while (1'b1) begin
      quot = mag / RADIX;
      digit_codes.push_front(CODE_A + CHAR_W'(mag % RADIX));
      if (quot == 0) break;
      mag = quot - 1'b1;
    end
    // Only the low digits survive when the spelling is too long.
    while (digit_codes.size() > MAX_DIGITS) void'(digit_codes.pop_front());
    if (v[WORD_W-1]) begin
      letter.code = CODE_MINUS;
      letter.last = 1'b0;
      expected_letters.push_back(letter);
    end
    foreach (digit_codes[i]) begin
      letter.code = digit_codes[i];
      letter.last = (i == digit_codes.size() - 1);
      expected_letters.push_back(letter);
    end
  endfunction

  // Input driver: presents the next word once the previous one has gone in.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 12);
      end else if (pending_values.size() > 0) begin
        in_valid <= 1'b1;
        value    <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off to fill the block up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (!long_hold_done && accepted_values >= HOLD_AT) begin
      out_ready      <= 1'b0;
      long_hold      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_gap   <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted word and checks every accepted character.
  always @(posedge clk) begin
    word_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        spell_value(value);
        accepted_values <= accepted_values + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_letters.size() == 0) begin
          $display("%0t: unexpected character, expected none, got code %0d last %0b",
                   $time, char_code, last_char);
          error_count = error_count + 1;
        end else begin
          if (char_code !== expected_letters[0].code) begin
            $display("%0t: char_code mismatch, expected %0d, got %0d",
                     $time, expected_letters[0].code, char_code);
            error_count = error_count + 1;
          end
          if (last_char !== expected_letters[0].last) begin
            $display("%0t: last_char mismatch, expected %0b, got %0b",
                     $time, expected_letters[0].last, last_char);
            error_count = error_count + 1;
          end
          void'(expected_letters.pop_front());
        end
      end
    end
  end

  // Stimulus: directed edge cases first, then a random mix of sizes and signs.
  initial begin
    logic signed [WORD_W-1:0] word;
    pending_values = '{0, 1, 4, 5, 6, 29, 30, 154, 155, 780, 3905,
                       -1, -4, -5, -6, -30, -155,
                       1525878904, 1525878905, -1525878905,
                       2147483647, -2147483647, 32'h8000_0000};
    for (int n = 0; n < 300; n++) begin
      case ($urandom_range(0, 2))
        0: word = $urandom_range(0, 400) - 200;
        1: word = $urandom;
        default: begin
          word = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) word = -word;
        end
      endcase
      pending_values.push_back(word);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_values.size() != 0 || in_valid) @(posedge clk);
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
